// File: hw/rtl/sincos_pkg.sv
// Types, constants and the Q30 multiply shared by the sine and cosine pipeline.
// Depends on nothing; every other file of the block but sincos_if imports it.
`default_nettype none

package sincos_pkg;

	localparam int FRAC      = 30;
	localparam int ACC_W     = 33;
	localparam int PROD_W    = 2 * ACC_W;
	localparam int HALF_PI_W = 33;
	localparam int MAX_TERMS = 10;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic [HALF_PI_W-1:0] HALF_PI_Q32 = 33'd6746518852;

	localparam acc_t SIN_COEF [MAX_TERMS] = '{
		33'sd1073741824, -33'sd178956971, 33'sd8947849, -33'sd213044, 33'sd2959,
		-33'sd27, 33'sd0, 33'sd0, 33'sd0, 33'sd0
	};

	localparam acc_t COS_COEF [MAX_TERMS] = '{
		33'sd1073741824, -33'sd536870912, 33'sd44739243, -33'sd1491308, 33'sd26631,
		-33'sd296, 33'sd2, 33'sd0, 33'sd0, 33'sd0
	};

	localparam logic [PROD_W-1:0] RND_HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC-1);

	typedef struct packed {
		logic valid;
		logic neg_s;
		logic neg_c;
		acc_t x;
		acc_t x2;
		acc_t s;
		acc_t c;
	} horner_word_t;

	// Product of two Q30 values, brought back to Q30 rounding half away from zero.
	function automatic acc_t mul_q30(input acc_t a, input acc_t b);
		logic signed [PROD_W-1:0] prod;
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] rnd;
		prod = PROD_W'(a) * PROD_W'(b);
		mag  = prod[PROD_W-1] ? unsigned'(-prod) : unsigned'(prod);
		rnd  = (mag + RND_HALF) >> FRAC;
		return prod[PROD_W-1] ? -signed'(rnd[ACC_W-1:0]) : signed'(rnd[ACC_W-1:0]);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sincos_if.sv
// Handshake channels of the block: the phase word in and the sine and cosine word out.
// Stand-alone; no package needed.
`default_nettype none

interface sincos_phase_if #(parameter int PHASE_BITS = 16) ();
	logic                  valid;
	logic                  ready;
	logic [PHASE_BITS-1:0] phase;

	modport source(output valid, output phase, input ready);
	modport sink(input valid, input phase, output ready);
endinterface

interface sincos_result_if #(parameter int OUT_BITS = 16) ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] sine;
	logic signed [OUT_BITS-1:0] cosine;

	modport source(output valid, output sine, output cosine, input ready);
	modport sink(input valid, input sine, input cosine, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sine_cosine_polynomial.sv
// Top level of the sine and cosine generator: fold front end, a row of Horner steps
// and the output stage. Depends on sincos_pkg, sincos_if and the three submodules.
//
//   channel   role    word
//   angle     sink    phase, PHASE_BITS bits unsigned, a full turn is 2^PHASE_BITS
//   result    source  sine and cosine, OUT_BITS bits signed, Q1.(OUT_BITS-1)
//
// One angle is taken in every cycle while the output register is empty or being taken;
// each word passes through three front stages, one stage per series term and two output stages.
// All stages advance together whenever the output register is empty or being taken.
// Reset clears the valid bits of every stage and the whole word handed along the row.
`default_nettype none

module sine_cosine_polynomial #(
	parameter int PHASE_BITS   = 16,
	parameter int OUT_BITS     = 16,
	parameter int SERIES_TERMS = 7
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sincos_phase_if.sink    angle,
	sincos_result_if.source result
);
	import sincos_pkg::*;

	logic         en;
	horner_word_t chain [SERIES_TERMS+1];

	assign en          = !result.valid || result.ready;
	assign angle.ready = en;

	sincos_fold #(
		.PHASE_BITS(PHASE_BITS)
	) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(angle.valid),
		.phase   (angle.phase),
		.word    (chain[0])
	);

	for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
		sincos_term #(
			.TERM(SERIES_TERMS - 1 - k)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.word_prev(chain[k]),
			.word     (chain[k+1])
		);
	end

	sincos_out #(
		.OUT_BITS(OUT_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.word_prev(chain[SERIES_TERMS]),
		.out_valid(result.valid),
		.sine     (result.sine),
		.cosine   (result.cosine)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[SERIES_TERMS]))
		else $error("Horner row moved while the output was stalled.");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> chain[SERIES_TERMS].valid == $past(chain[SERIES_TERMS-1].valid))
		else $error("Valid bit lost or invented in the Horner row.");

	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result.valid) |-> $past(result.ready))
		else $error("Result word withdrawn before it was taken.");

endmodule

`default_nettype wire

// File: hw/rtl/sincos_fold.sv
// Front end: quadrant fold, scaling to Q30 radians and squaring, three stages.
// Depends on sincos_pkg.
`default_nettype none

module sincos_fold #(
	parameter int PHASE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [PHASE_BITS-1:0]  phase,
	output sincos_pkg::horner_word_t    word
);
	import sincos_pkg::*;

	localparam int A_W = PHASE_BITS - 1;
	localparam int P_W = A_W + HALF_PI_W;
	localparam logic [PHASE_BITS:0] QTR  = (PHASE_BITS+1)'(1) << (PHASE_BITS-2);
	localparam logic [PHASE_BITS:0] HALF = QTR << 1;
	localparam logic [PHASE_BITS:0] TQTR = QTR + HALF;
	localparam logic [PHASE_BITS:0] FULL = QTR << 2;
	localparam logic [P_W-1:0] RND_X = P_W'(1) << (PHASE_BITS-1);

	logic [PHASE_BITS:0] ext;
	logic [PHASE_BITS:0] a_full;
	logic                neg_s_d;
	logic                neg_c_d;
	logic [P_W-1:0]      scaled;

	logic           valid_s1, valid_s2;
	logic [A_W-1:0] a_s1;
	logic           neg_s_s1, neg_c_s1, neg_s_s2, neg_c_s2;
	acc_t           x_s2;

	always_comb begin
		ext     = {1'b0, phase};
		neg_s_d = 1'b0;
		neg_c_d = 1'b0;
		if (ext <= QTR) begin
			a_full = ext;
		end else if (ext <= HALF) begin
			a_full  = HALF - ext;
			neg_c_d = 1'b1;
		end else if (ext <= TQTR) begin
			a_full  = ext - HALF;
			neg_s_d = 1'b1;
			neg_c_d = 1'b1;
		end else begin
			a_full  = FULL - ext;
			neg_s_d = 1'b1;
		end
	end

	assign scaled = P_W'(a_s1) * P_W'(HALF_PI_Q32) + RND_X;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			word     <= '0;
		end else if (en) begin
			valid_s1   <= in_valid;
			valid_s2   <= valid_s1;
			word.valid <= valid_s2;
			word.neg_s <= neg_s_s2;
			word.neg_c <= neg_c_s2;
			word.x     <= x_s2;
			word.x2    <= mul_q30(x_s2, x_s2);
			word.s     <= '0;
			word.c     <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a_full[A_W-1:0];
			neg_s_s1 <= neg_s_d;
			neg_c_s1 <= neg_c_d;
			x_s2     <= signed'({2'b00, scaled[PHASE_BITS+30:PHASE_BITS]});
			neg_s_s2 <= neg_s_s1;
			neg_c_s2 <= neg_c_s1;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sincos_term.sv
// One Horner step for both series: multiply by the squared angle and add a coefficient.
// Depends on sincos_pkg.
`default_nettype none

module sincos_term #(
	parameter int TERM = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  sincos_pkg::horner_word_t word_prev,
	output sincos_pkg::horner_word_t word
);
	import sincos_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word <= '0;
		end else if (en) begin
			word.valid <= word_prev.valid;
			word.neg_s <= word_prev.neg_s;
			word.neg_c <= word_prev.neg_c;
			word.x     <= word_prev.x;
			word.x2    <= word_prev.x2;
			word.s     <= mul_q30(word_prev.s, word_prev.x2) + SIN_COEF[TERM];
			word.c     <= mul_q30(word_prev.c, word_prev.x2) + COS_COEF[TERM];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sincos_out.sv
// Back end: final multiply of the sine series by the angle, then rounding to the
// output format, quadrant signs and saturation. Depends on sincos_pkg.
`default_nettype none

module sincos_out #(
	parameter int OUT_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  sincos_pkg::horner_word_t        word_prev,
	output logic                            out_valid,
	output logic signed [OUT_BITS-1:0]      sine,
	output logic signed [OUT_BITS-1:0]      cosine
);
	import sincos_pkg::*;

	localparam int R_W = ACC_W + 2;
	localparam int SHR = (OUT_BITS - 1 < FRAC) ? FRAC - OUT_BITS + 1 : 1;
	localparam logic signed [R_W-1:0] MAX_V = signed'((R_W'(1) << (OUT_BITS-1)) - R_W'(1));
	localparam logic signed [R_W-1:0] MIN_V = -MAX_V - R_W'(1);
	localparam logic [ACC_W-1:0] RND_O = ACC_W'(1) << (SHR-1);

	function automatic logic signed [OUT_BITS-1:0] to_out(input acc_t v, input logic neg);
		logic [ACC_W-1:0]        mag;
		logic [ACC_W-1:0]        rnd;
		logic signed [R_W-1:0]   r;
		mag = v[ACC_W-1] ? unsigned'(-v) : unsigned'(v);
		rnd = (mag + RND_O) >> SHR;
		if (OUT_BITS - 1 < FRAC) begin
			r = v[ACC_W-1] ? -signed'(R_W'(rnd)) : signed'(R_W'(rnd));
		end else if (OUT_BITS - 1 == FRAC) begin
			r = R_W'(v);
		end else begin
			r = R_W'(v) <<< 1;
		end
		if (neg) begin
			r = -r;
		end
		if (r > MAX_V) begin
			r = MAX_V;
		end else if (r < MIN_V) begin
			r = MIN_V;
		end
		return r[OUT_BITS-1:0];
	endfunction

	logic valid_s1;
	logic neg_s_s1, neg_c_s1;
	acc_t s_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= word_prev.valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1     <= mul_q30(word_prev.s, word_prev.x);
			c_s1     <= word_prev.c;
			neg_s_s1 <= word_prev.neg_s;
			neg_c_s1 <= word_prev.neg_c;
			sine     <= to_out(s_s1, neg_s_s1);
			cosine   <= to_out(c_s1, neg_c_s1);
		end
	end

endmodule

`default_nettype wire

// File: sim/tb_sine_cosine_polynomial.sv
// Self-checking testbench for sine_cosine_polynomial: drives phase words, predicts each
// sine and cosine word bit for bit in fixed point and compares every result in order.
// Depends on sincos_pkg, sincos_if and the block's RTL; reads no files.
`timescale 1ns / 1ps

module tb_sine_cosine_polynomial;

	import sincos_pkg::*;

	localparam int PHASE_BITS   = 16;
	localparam int OUT_BITS     = 16;
	localparam int SERIES_TERMS = 7;
	localparam int PIPE_DEPTH   = SERIES_TERMS + 5;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int Q30_SHIFT    = 30;
	localparam int QUARTER_TURN = 1 << (PHASE_BITS - 2);
	localparam longint unsigned HALF_PI_Q32_VALUE = 64'd6746518852;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] sine;
		logic signed [OUT_BITS-1:0] cosine;
	} sincos_word_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   error_count;
	int   burst_left;
	int   stall_mode;

	sincos_word_t expected_words [$];

	sincos_phase_if  #(.PHASE_BITS(PHASE_BITS)) angle_ch ();
	sincos_result_if #(.OUT_BITS(OUT_BITS))     result_ch ();

	sine_cosine_polynomial #(
		.PHASE_BITS  (PHASE_BITS),
		.OUT_BITS    (OUT_BITS),
		.SERIES_TERMS(SERIES_TERMS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.angle (angle_ch),
		.result(result_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Signed right shift that rounds half away from zero.
	function automatic longint shift_round_away(input longint v, input int k);
		longint unsigned mag;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		mag = (mag + (64'd1 << (k - 1))) >> k;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint q30_product(input longint a, input longint b);
		return shift_round_away(a * b, Q30_SHIFT);
	endfunction

	function automatic longint taylor_coef_q30(input bit cosine_series, input int idx);
		if (cosine_series) begin
			case (idx)
				0: return 64'sd1073741824;
				1: return -64'sd536870912;
				2: return 64'sd44739243;
				3: return -64'sd1491308;
				4: return 64'sd26631;
				5: return -64'sd296;
				6: return 64'sd2;
				default: return 64'sd0;
			endcase
		end else begin
			case (idx)
				0: return 64'sd1073741824;
				1: return -64'sd178956971;
				2: return 64'sd8947849;
				3: return -64'sd213044;
				4: return 64'sd2959;
				5: return -64'sd27;
				default: return 64'sd0;
			endcase
		end
	endfunction

	function automatic logic signed [OUT_BITS-1:0] quantise_output(input longint v,
			input bit negate);
		longint r;
		longint lim;
		lim = longint'(1) << (OUT_BITS - 1);
		if (OUT_BITS - 1 == Q30_SHIFT)
			r = v;
		else if (OUT_BITS - 1 < Q30_SHIFT)
			r = shift_round_away(v, Q30_SHIFT - (OUT_BITS - 1));
		else
			r = v * (longint'(1) << (OUT_BITS - 1 - Q30_SHIFT));
		if (negate)
			r = -r;
		if (r > lim - 1)
			r = lim - 1;
		if (r < -lim)
			r = -lim;
		return r[OUT_BITS-1:0];
	endfunction

	// Folds the angle into the first quadrant, evaluates both series and restores signs.
	function automatic sincos_word_t predict_sincos(input logic [PHASE_BITS-1:0] phase);
		longint unsigned p;
		longint unsigned folded;
		longint x;
		longint x2;
		longint s;
		longint c;
		bit neg_sine;
		bit neg_cosine;
		sincos_word_t word;
		p = 64'(phase);
		neg_sine = 1'b0;
		neg_cosine = 1'b0;
		if (p <= QUARTER_TURN) begin
			folded = p;
		end else if (p <= 2 * QUARTER_TURN) begin
			folded = 2 * QUARTER_TURN - p;
			neg_cosine = 1'b1;
		end else if (p <= 3 * QUARTER_TURN) begin
			folded = p - 2 * QUARTER_TURN;
			neg_sine = 1'b1;
			neg_cosine = 1'b1;
		end else begin
			folded = 4 * QUARTER_TURN - p;
			neg_sine = 1'b1;
		end
		x = longint'((folded * HALF_PI_Q32_VALUE + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS);
		x2 = q30_product(x, x);
		s = 0;
		c = 0;
		for (int t = SERIES_TERMS - 1; t >= 0; t--) begin
			s = q30_product(s, x2) + taylor_coef_q30(1'b0, t);
			c = q30_product(c, x2) + taylor_coef_q30(1'b1, t);
		end
		s = q30_product(s, x);
		word.sine = quantise_output(s, neg_sine);
		word.cosine = quantise_output(c, neg_cosine);
		return word;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Sends one phase word; the sender works in bursts, with a random gap before most bursts.
	task automatic send_phase(input logic [PHASE_BITS-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				angle_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		angle_ch.valid <= 1'b1;
		angle_ch.phase <= value;
		do @(posedge clk); while (!angle_ch.ready);
		expected_words.push_back(predict_sincos(value));
	endtask

	task automatic test_axis_angles();
		send_phase(16'd0);
		send_phase(16'(QUARTER_TURN));
		send_phase(16'(2 * QUARTER_TURN));
		send_phase(16'(3 * QUARTER_TURN));
		send_phase(16'hFFFF);
		send_phase(16'd1);
	endtask

	task automatic test_quadrant_boundaries();
		for (int k = 1; k <= 3; k++) begin
			send_phase(16'(k * QUARTER_TURN - 1));
			send_phase(16'(k * QUARTER_TURN + 1));
		end
		for (int k = 0; k < 4; k++)
			send_phase(16'(k * QUARTER_TURN + QUARTER_TURN / 2));
		send_phase(16'h5555);
		send_phase(16'hAAAA);
		send_phase(16'h8001);
	endtask

	task automatic test_random_angles(input int count);
		logic [PHASE_BITS-1:0] value;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7)
				value = PHASE_BITS'($urandom);
			else
				value = 16'($urandom_range(0, 3) * QUARTER_TURN + $urandom_range(0, 16) - 8);
			send_phase(value);
		end
	endtask

	// Phase accumulator as an oscillator would drive it, wrapping modulo a full turn.
	task automatic test_accumulator_sweep(input int sweeps, input int length);
		logic [PHASE_BITS-1:0] acc;
		logic [PHASE_BITS-1:0] step;
		for (int n = 0; n < sweeps; n++) begin
			acc = PHASE_BITS'($urandom);
			step = PHASE_BITS'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom);
			for (int i = 0; i < length; i++) begin
				send_phase(acc);
				acc = acc + step;
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls in one of four patterns, picked anew at random.
	always @(posedge clk) begin
		if (cycle_count % 128 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= ($urandom_range(0, 3) != 0);
			2: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= cycle_count[2];
		endcase
	end

	always @(posedge clk) begin : check_result
		sincos_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word sine %0d cosine %0d",
					result_ch.sine, result_ch.cosine));
			end else begin
				want = expected_words.pop_front();
				if (result_ch.sine !== want.sine)
					report_mismatch($sformatf("sine %0d, expected %0d",
						result_ch.sine, want.sine));
				if (result_ch.cosine !== want.cosine)
					report_mismatch($sformatf("cosine %0d, expected %0d",
						result_ch.cosine, want.cosine));
			end
		end
	end

	initial begin
		cycle_count = 0;
		error_count = 0;
		burst_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		angle_ch.valid = 1'b0;
		angle_ch.phase = '0;
		result_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_angles();
		test_quadrant_boundaries();
		test_random_angles(600);
		test_accumulator_sweep(3, 100);
		angle_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
